FILE: src/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg: shared types and codes for the banker's resource allocator
// request kinds, result status codes, payload structs and unit vectors
// ----------------------------------------------------------------------------
package bra_pkg;

	localparam int TYPES_MAX  = 4;
	localparam int AMT_W      = 8;
	localparam int ID_W       = 3;
	localparam int ST_W       = 4;
	localparam int NUM_TOTALS = 4;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	typedef enum logic [1:0] {
		REQ_CLAIM   = 2'd0,
		REQ_ACQUIRE = 2'd1,
		REQ_RELEASE = 2'd2,
		REQ_UNUSED  = 2'd3
	} req_kind_t;

	typedef enum logic [ST_W-1:0] {
		ST_CLAIM_OK   = 4'd0,
		ST_CLAIM_REJ  = 4'd1,
		ST_GRANTED    = 4'd2,
		ST_OVER_CLAIM = 4'd3,
		ST_WAIT_SHORT = 4'd4,
		ST_WAIT_UNSAFE = 4'd5,
		ST_RELEASED   = 4'd6,
		ST_WAITER_OK  = 4'd7,
		ST_BUSY       = 4'd8
	} status_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [ID_W-1:0]  process_id;
		logic [AMT_W-1:0] amount_type0;
		logic [AMT_W-1:0] amount_type1;
		logic [AMT_W-1:0] amount_type2;
		logic [AMT_W-1:0] amount_type3;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]  result_process;
		logic [ST_W-1:0]  status;
		logic [AMT_W-1:0] units_type0;
		logic [AMT_W-1:0] units_type1;
		logic [AMT_W-1:0] units_type2;
		logic [AMT_W-1:0] units_type3;
		logic             last_result;
	} out_item_t;

	typedef logic [TYPES_MAX-1:0][AMT_W-1:0] unit_vec_t;

	// handshake from the safety checker back to the sequencer
	typedef struct packed {
		logic fin;
		logic safe;
	} sc_status_t;

endpackage

FILE: src/bra_safety.sv
// ----------------------------------------------------------------------------
// bra_safety: banker's safety check
// walks one process row per cycle, up to PROCESSES passes, with one shared
// need-versus-work compare and one work accumulator
// ----------------------------------------------------------------------------
module bra_safety #(
	parameter int PROCESSES      = 8,
	parameter int RESOURCE_TYPES = 4
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          start,
	input  logic [RESOURCE_TYPES-1:0][bra_pkg::AMT_W-1:0] avail,
	output logic [((PROCESSES > 1) ? $clog2(PROCESSES) : 1)-1:0] row_idx,
	input  logic [RESOURCE_TYPES-1:0][bra_pkg::AMT_W-1:0] claim_row,
	input  logic [RESOURCE_TYPES-1:0][bra_pkg::AMT_W-1:0] held_row,
	output bra_pkg::sc_status_t                           status
);

	localparam int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
	localparam int WW = bra_pkg::AMT_W + 1 + $clog2(PROCESSES + 1);

	logic                                 run_q;
	logic [RESOURCE_TYPES-1:0][WW-1:0]    work_q;
	logic [PROCESSES-1:0]                 done_q;
	logic [PW-1:0]                        idx_q;
	logic [PW-1:0]                        pass_q;
	logic                                 found_q;
	logic                                 fin_q;
	logic                                 safe_q;

	logic                                 fits;
	logic [PROCESSES-1:0]                 done_nx;
	logic [bra_pkg::AMT_W-1:0]            need;

	always_comb begin
		fits = !done_q[idx_q];
		need = '0;
		for (int r = 0; r < RESOURCE_TYPES; r++) begin
			need = (claim_row[r] > held_row[r]) ? claim_row[r] - held_row[r] : '0;
			if (WW'(need) > work_q[r]) begin
				fits = 1'b0;
			end
		end
		done_nx = done_q;
		if (fits) begin
			done_nx[idx_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			fin_q   <= 1'b0;
			safe_q  <= 1'b0;
			idx_q   <= '0;
			pass_q  <= '0;
			found_q <= 1'b0;
			done_q  <= '0;
			work_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				run_q   <= 1'b1;
				idx_q   <= '0;
				pass_q  <= '0;
				found_q <= 1'b0;
				done_q  <= '0;
				for (int r = 0; r < RESOURCE_TYPES; r++) begin
					work_q[r] <= WW'(avail[r]);
				end
			end else if (run_q) begin
				done_q <= done_nx;
				if (fits) begin
					for (int r = 0; r < RESOURCE_TYPES; r++) begin
						work_q[r] <= work_q[r] + WW'(held_row[r]);
					end
				end
				if (idx_q == PW'(PROCESSES - 1)) begin
					// end of a pass: stop when nothing finished or passes ran out
					if (!(found_q || fits) || pass_q == PW'(PROCESSES - 1)) begin
						run_q  <= 1'b0;
						fin_q  <= 1'b1;
						safe_q <= &done_nx;
					end else begin
						pass_q  <= pass_q + 1'b1;
						idx_q   <= '0;
						found_q <= 1'b0;
					end
				end else begin
					idx_q   <= idx_q + 1'b1;
					found_q <= found_q || fits;
				end
			end
		end
	end

	assign row_idx     = idx_q;
	assign status.fin  = fin_q;
	assign status.safe = safe_q;

endmodule

FILE: src/bankers_resource_allocator_core.sv
// ----------------------------------------------------------------------------
// bankers_resource_allocator_core: banker's algorithm resource allocator
// claim, request and release handling with deadlock avoidance
// ----------------------------------------------------------------------------
// One request at a time. A claim, a rejected request, a request that waits
// short of units, or a request from a waiting process has its result
// registered in S_EXEC and held in S_OUT until taken. A request that passes
// the fit checks runs the safety check: one process row per cycle, up to
// PROCESSES passes. A release then walks every process in ascending order;
// each waiter that fits the pool costs one more safety check. The safety
// checker has a single compare/accumulate lane. in_stall stays high from
// acceptance until the last result (last_result = 1) has been taken. The pool
// sizes are programmed through the APB port, register i at byte 4*i; writing
// one reloads that type's available units as total minus held, floored at 0.
// ----------------------------------------------------------------------------
module bankers_resource_allocator_core #(
	parameter int PROCESSES      = 8,
	parameter int RESOURCE_TYPES = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  bra_pkg::in_item_t             in_data,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output bra_pkg::out_item_t            out_data,
	// apb configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bra_pkg::ADDR_W-1:0]    paddr,
	input  logic [bra_pkg::DATA_W-1:0]    pwdata,
	output logic [bra_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	localparam int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
	localparam int QW = $clog2(PROCESSES + 1);
	localparam int SW = bra_pkg::AMT_W + $clog2(PROCESSES + 1);
	localparam int AW = bra_pkg::AMT_W;

	typedef logic [RESOURCE_TYPES-1:0][AW-1:0] vec_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_SAFE = 5'b00100,
		S_SCAN = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t                  state_q;
	state_t                  ret_q;
	logic                    mode_q;       // 1: safety check for a waiter
	bra_pkg::in_item_t       in_q;
	vec_t                    gamt_q;       // units tentatively granted
	logic [PW-1:0]           gidx_q;       // process they went to
	logic [QW-1:0]           q_idx_q;      // waiter scan position
	bra_pkg::out_item_t      hold_q;       // result held back until its last flag is known
	bra_pkg::out_item_t      hold_fin;     // held result marked as the final one
	bra_pkg::out_item_t      out_q;
	logic                    out_valid_q;
	logic                    start_q;

	// per-process tables and pool state
	vec_t                    claim_q [PROCESSES];
	vec_t                    held_q  [PROCESSES];
	vec_t                    pend_q  [PROCESSES];
	logic [PROCESSES-1:0]    wait_q;
	vec_t                    avail_q;
	logic [RESOURCE_TYPES-1:0][SW-1:0] hsum_q;  // units held per type, all processes
	logic [bra_pkg::NUM_TOTALS-1:0][AW-1:0] total_q;

	bra_pkg::sc_status_t     sc_status;
	logic [PW-1:0]           sc_idx;
	bra_pkg::unit_vec_t      in_amt4;
	vec_t                    amt;
	vec_t                    rel;
	vec_t                    avail_rel;
	logic [PW-1:0]           pid_idx;
	logic [PW-1:0]           q_row;
	logic [PW-1:0]           rd_idx;
	vec_t                    claim_rd;
	vec_t                    held_rd;
	vec_t                    pend_rd;
	logic                    claim_ok;
	logic                    over;
	logic                    short_req;
	logic                    short_wait;
	logic                    cfg_wr;
	logic [1:0]              cfg_idx;
	logic [AW:0]             avail_sum;

	function automatic bra_pkg::out_item_t make_out(
		input logic [bra_pkg::ID_W-1:0] proc,
		input bra_pkg::status_t         st,
		input vec_t                     units,
		input logic                     last
	);
		bra_pkg::unit_vec_t u4;
		bra_pkg::out_item_t o;
		u4 = '0;
		for (int r = 0; r < RESOURCE_TYPES; r++) begin
			u4[r] = units[r];
		end
		o.result_process = proc;
		o.status         = st;
		o.units_type0    = u4[0];
		o.units_type1    = u4[1];
		o.units_type2    = u4[2];
		o.units_type3    = u4[3];
		o.last_result    = last;
		return o;
	endfunction

	// request amounts as a lane vector, types beyond the configured count dropped
	assign in_amt4 = {in_q.amount_type3, in_q.amount_type2,
		in_q.amount_type1, in_q.amount_type0};

	always_comb begin
		for (int r = 0; r < RESOURCE_TYPES; r++) begin
			amt[r] = in_amt4[r];
		end
	end

	assign pid_idx = PW'(in_q.process_id);
	assign q_row   = q_idx_q[PW-1:0];
	// one row port: the safety checker owns it while it runs
	assign rd_idx   = (state_q == S_SAFE) ? sc_idx : pid_idx;
	assign claim_rd = claim_q[rd_idx];
	assign held_rd  = held_q[rd_idx];
	assign pend_rd  = pend_q[q_row];

	always_comb begin
		hold_fin             = hold_q;
		hold_fin.last_result = 1'b1;
	end

	// decisions on the current request row
	always_comb begin
		claim_ok   = 1'b1;
		over       = 1'b0;
		short_req  = 1'b0;
		short_wait = 1'b0;
		avail_sum  = '0;
		for (int r = 0; r < RESOURCE_TYPES; r++) begin
			if (amt[r] > total_q[r] || amt[r] < held_rd[r]) begin
				claim_ok = 1'b0;
			end
			if (amt[r] > ((claim_rd[r] > held_rd[r]) ? claim_rd[r] - held_rd[r] : '0)) begin
				over = 1'b1;
			end
			if (amt[r] > avail_q[r]) begin
				short_req = 1'b1;
			end
			if (pend_rd[r] > avail_q[r]) begin
				short_wait = 1'b1;
			end
			// release saturates at the units held, pool saturates at full scale
			rel[r]       = (amt[r] > held_rd[r]) ? held_rd[r] : amt[r];
			avail_sum    = {1'b0, avail_q[r]} + {1'b0, rel[r]};
			avail_rel[r] = avail_sum[AW] ? {AW{1'b1}} : avail_sum[AW-1:0];
		end
	end

	bra_safety #(
		.PROCESSES      (PROCESSES),
		.RESOURCE_TYPES (RESOURCE_TYPES)
	) u_safety (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.avail     (avail_q),
		.row_idx   (sc_idx),
		.claim_row (claim_rd),
		.held_row  (held_rd),
		.status    (sc_status)
	);

	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign prdata  = bra_pkg::DATA_W'(total_q[cfg_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			mode_q      <= 1'b0;
			in_q        <= '0;
			gamt_q      <= '0;
			hold_q      <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			start_q     <= 1'b0;
			q_idx_q     <= '0;
			gidx_q      <= '0;
			wait_q      <= '0;
			avail_q     <= '0;
			hsum_q      <= '0;
			total_q     <= '0;
			for (int p = 0; p < PROCESSES; p++) begin
				claim_q[p] <= '0;
				held_q[p]  <= '0;
				pend_q[p]  <= '0;
			end
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_q <= in_data;
						// unused selector and unknown process give no result
						if (in_data.req_type != bra_pkg::REQ_UNUSED
							&& int'(in_data.process_id) < PROCESSES) begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					ret_q <= S_IDLE;
					if (wait_q[pid_idx]) begin
						out_q       <= make_out(in_q.process_id, bra_pkg::ST_BUSY, '0, 1'b1);
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						case (bra_pkg::req_kind_t'(in_q.req_type))
							bra_pkg::REQ_CLAIM: begin
								if (claim_ok) begin
									claim_q[pid_idx] <= amt;
								end
								out_q <= make_out(in_q.process_id,
									claim_ok ? bra_pkg::ST_CLAIM_OK : bra_pkg::ST_CLAIM_REJ,
									'0, 1'b1);
								out_valid_q <= 1'b1;
								state_q     <= S_OUT;
							end
							bra_pkg::REQ_ACQUIRE: begin
								if (over) begin
									out_q <= make_out(in_q.process_id,
										bra_pkg::ST_OVER_CLAIM, '0, 1'b1);
									out_valid_q <= 1'b1;
									state_q     <= S_OUT;
								end else if (short_req) begin
									pend_q[pid_idx] <= amt;
									wait_q[pid_idx] <= 1'b1;
									out_q <= make_out(in_q.process_id,
										bra_pkg::ST_WAIT_SHORT, '0, 1'b1);
									out_valid_q <= 1'b1;
									state_q     <= S_OUT;
								end else begin
									// tentative grant, safety check decides
									for (int r = 0; r < RESOURCE_TYPES; r++) begin
										avail_q[r]         <= avail_q[r] - amt[r];
										held_q[pid_idx][r] <= held_rd[r] + amt[r];
										hsum_q[r]          <= hsum_q[r] + SW'(amt[r]);
									end
									gamt_q  <= amt;
									gidx_q  <= pid_idx;
									mode_q  <= 1'b0;
									start_q <= 1'b1;
									state_q <= S_SAFE;
								end
							end
							bra_pkg::REQ_RELEASE: begin
								for (int r = 0; r < RESOURCE_TYPES; r++) begin
									held_q[pid_idx][r] <= held_rd[r] - rel[r];
									hsum_q[r]          <= hsum_q[r] - SW'(rel[r]);
									avail_q[r]         <= avail_rel[r];
								end
								hold_q  <= make_out(in_q.process_id, bra_pkg::ST_RELEASED,
									rel, 1'b0);
								q_idx_q <= '0;
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SAFE: begin
					if (sc_status.fin) begin
						if (sc_status.safe) begin
							if (!mode_q) begin
								out_q <= make_out(in_q.process_id, bra_pkg::ST_GRANTED,
									gamt_q, 1'b1);
								ret_q <= S_IDLE;
							end else begin
								pend_q[gidx_q] <= '0;
								wait_q[gidx_q] <= 1'b0;
								// previous result goes out, this grant is held back
								out_q   <= hold_q;
								hold_q  <= make_out(bra_pkg::ID_W'(gidx_q),
									bra_pkg::ST_WAITER_OK, gamt_q, 1'b0);
								q_idx_q <= q_idx_q + 1'b1;
								ret_q   <= S_SCAN;
							end
							out_valid_q <= 1'b1;
							state_q     <= S_OUT;
						end else begin
							// undo the tentative grant
							for (int r = 0; r < RESOURCE_TYPES; r++) begin
								avail_q[r]        <= avail_q[r] + gamt_q[r];
								held_q[gidx_q][r] <= held_q[gidx_q][r] - gamt_q[r];
								hsum_q[r]         <= hsum_q[r] - SW'(gamt_q[r]);
							end
							if (!mode_q) begin
								pend_q[gidx_q] <= gamt_q;
								wait_q[gidx_q] <= 1'b1;
								out_q <= make_out(in_q.process_id, bra_pkg::ST_WAIT_UNSAFE,
									'0, 1'b1);
								out_valid_q <= 1'b1;
								ret_q       <= S_IDLE;
								state_q     <= S_OUT;
							end else begin
								q_idx_q <= q_idx_q + 1'b1;
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					if (q_idx_q == QW'(PROCESSES)) begin
						// scan over: the held result is the final one
						out_q       <= hold_fin;
						out_valid_q <= 1'b1;
						ret_q       <= S_IDLE;
						state_q     <= S_OUT;
					end else if (wait_q[q_row] && !short_wait) begin
						for (int r = 0; r < RESOURCE_TYPES; r++) begin
							avail_q[r]       <= avail_q[r] - pend_rd[r];
							held_q[q_row][r] <= held_q[q_row][r] + pend_rd[r];
							hsum_q[r]        <= hsum_q[r] + SW'(pend_rd[r]);
						end
						gamt_q  <= pend_rd;
						gidx_q  <= q_row;
						mode_q  <= 1'b1;
						start_q <= 1'b1;
						state_q <= S_SAFE;
					end else begin
						q_idx_q <= q_idx_q + 1'b1;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= ret_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// pool size write reloads the available units of that type
			if (cfg_wr) begin
				total_q[cfg_idx] <= pwdata[AW-1:0];
				for (int r = 0; r < RESOURCE_TYPES; r++) begin
					if (cfg_idx == 2'(r)) begin
						avail_q[r] <= (SW'(pwdata[AW-1:0]) > hsum_q[r])
							? AW'(SW'(pwdata[AW-1:0]) - hsum_q[r]) : '0;
					end
				end
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: tb/sv/bra_checker.sv
// ----------------------------------------------------------------------------
// bra_checker: result predictor and scoreboard for the banker's allocator
// watches the request, result and apb channels, predicts every result and
// compares it field by field with what the block delivers
// ----------------------------------------------------------------------------
module bra_checker #(
	parameter int PROCESSES      = 8,
	parameter int RESOURCE_TYPES = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  bra_pkg::in_item_t          in_data,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  bra_pkg::out_item_t         out_data,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [bra_pkg::ADDR_W-1:0] paddr,
	input  logic [bra_pkg::DATA_W-1:0] pwdata,
	output int                         errors,
	output int                         pending_cnt,
	output int                         result_cnt,
	output int                         grant_cnt,
	output int                         wait_cnt
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0] totals [bra_pkg::NUM_TOTALS];
	logic [7:0] claim [PROCESSES][RESOURCE_TYPES];
	logic [7:0] held [PROCESSES][RESOURCE_TYPES];
	logic [7:0] pend [PROCESSES][RESOURCE_TYPES];
	logic       waiting [PROCESSES];
	logic [7:0] avail [RESOURCE_TYPES];
	bra_pkg::out_item_t expected_results [$];

	assign pending_cnt = expected_results.size();

	task automatic report(input string what, input bra_pkg::out_item_t got,
			input bra_pkg::out_item_t exp);
		errors++;
		$display("[%0t] mismatch %s: got %p expected %p", $time, what, got, exp);
	endtask

	function automatic logic [7:0] need(int p, int r);
		return claim[p][r] > held[p][r] ? claim[p][r] - held[p][r] : 8'd0;
	endfunction

	function automatic bit is_safe();
		int  work [RESOURCE_TYPES];
		bit  done [PROCESSES];
		bit  found, fits;
		for (int r = 0; r < RESOURCE_TYPES; r++) work[r] = avail[r];
		for (int p = 0; p < PROCESSES; p++) done[p] = 0;
		for (int pass = 0; pass < PROCESSES; pass++) begin
			found = 0;
			for (int p = 0; p < PROCESSES; p++) begin
				fits = !done[p];
				for (int r = 0; r < RESOURCE_TYPES; r++)
					if (need(p, r) > work[r]) fits = 0;
				if (fits) begin
					for (int r = 0; r < RESOURCE_TYPES; r++) work[r] += held[p][r];
					done[p] = 1;
					found = 1;
				end
			end
			if (!found) break;
		end
		foreach (done[p]) if (!done[p]) return 0;
		return 1;
	endfunction

	// 0 granted, 1 short of units, 2 unsafe
	function automatic int try_grant(int p, logic [7:0] amt [RESOURCE_TYPES]);
		for (int r = 0; r < RESOURCE_TYPES; r++)
			if (amt[r] > avail[r]) return 1;
		for (int r = 0; r < RESOURCE_TYPES; r++) begin
			avail[r] -= amt[r];
			held[p][r] += amt[r];
		end
		if (is_safe()) return 0;
		for (int r = 0; r < RESOURCE_TYPES; r++) begin
			avail[r] += amt[r];
			held[p][r] -= amt[r];
		end
		return 2;
	endfunction

	function automatic bra_pkg::out_item_t mk(int p, bra_pkg::status_t st,
			logic [7:0] u [RESOURCE_TYPES], bit with_units);
		bra_pkg::out_item_t o;
		logic [7:0] v [4];
		for (int r = 0; r < 4; r++)
			v[r] = (with_units && r < RESOURCE_TYPES) ? u[r] : 8'd0;
		o.result_process = p[bra_pkg::ID_W-1:0];
		o.status = st;
		o.units_type0 = v[0];
		o.units_type1 = v[1];
		o.units_type2 = v[2];
		o.units_type3 = v[3];
		o.last_result = 1'b0;
		return o;
	endfunction

	function automatic void write_total(int idx, logic [7:0] val);
		int sum;
		sum = 0;
		if (idx >= bra_pkg::NUM_TOTALS) return;
		totals[idx] = val;
		if (idx >= RESOURCE_TYPES) return;
		for (int p = 0; p < PROCESSES; p++) sum += held[p][idx];
		avail[idx] = (val > sum) ? 8'(val - sum) : 8'd0;
	endfunction

	// predicts every result caused by one accepted request
	function automatic void predict_request(bra_pkg::in_item_t it);
		logic [7:0] amt [RESOURCE_TYPES];
		logic [7:0] pq [RESOURCE_TYPES];
		logic [7:0] raw [4];
		bra_pkg::out_item_t res [$];
		int         p, code, a;
		bit         ok;
		p = it.process_id;
		raw = '{it.amount_type0, it.amount_type1, it.amount_type2, it.amount_type3};
		if (it.req_type == bra_pkg::REQ_UNUSED || p >= PROCESSES) return;
		for (int r = 0; r < RESOURCE_TYPES; r++) amt[r] = raw[r];
		if (waiting[p]) begin
			res.push_back(mk(p, bra_pkg::ST_BUSY, amt, 0));
		end else if (it.req_type == bra_pkg::REQ_CLAIM) begin
			ok = 1;
			for (int r = 0; r < RESOURCE_TYPES; r++)
				if (amt[r] > totals[r] || amt[r] < held[p][r]) ok = 0;
			if (ok) for (int r = 0; r < RESOURCE_TYPES; r++) claim[p][r] = amt[r];
			res.push_back(mk(p, ok ? bra_pkg::ST_CLAIM_OK : bra_pkg::ST_CLAIM_REJ, amt, 0));
		end else if (it.req_type == bra_pkg::REQ_ACQUIRE) begin
			ok = 1;
			for (int r = 0; r < RESOURCE_TYPES; r++)
				if (amt[r] > need(p, r)) ok = 0;
			if (!ok) begin
				res.push_back(mk(p, bra_pkg::ST_OVER_CLAIM, amt, 0));
			end else begin
				code = try_grant(p, amt);
				if (code == 0) begin
					res.push_back(mk(p, bra_pkg::ST_GRANTED, amt, 1));
					grant_cnt++;
				end else begin
					for (int r = 0; r < RESOURCE_TYPES; r++) pend[p][r] = amt[r];
					waiting[p] = 1;
					wait_cnt++;
					res.push_back(mk(p, code == 1 ? bra_pkg::ST_WAIT_SHORT
						: bra_pkg::ST_WAIT_UNSAFE, amt, 0));
				end
			end
		end else begin
			// release saturates at the units held, pool saturates at 255
			for (int r = 0; r < RESOURCE_TYPES; r++) begin
				if (amt[r] > held[p][r]) amt[r] = held[p][r];
				held[p][r] -= amt[r];
				a = avail[r] + amt[r];
				avail[r] = a > 255 ? 8'd255 : a[7:0];
			end
			res.push_back(mk(p, bra_pkg::ST_RELEASED, amt, 1));
			for (int q = 0; q < PROCESSES; q++) begin
				if (!waiting[q]) continue;
				for (int r = 0; r < RESOURCE_TYPES; r++) pq[r] = pend[q][r];
				if (try_grant(q, pq) == 0) begin
					for (int r = 0; r < RESOURCE_TYPES; r++) pend[q][r] = 0;
					waiting[q] = 0;
					res.push_back(mk(q, bra_pkg::ST_WAITER_OK, pq, 1));
				end
			end
		end
		res[res.size()-1].last_result = 1'b1;
		foreach (res[i]) expected_results.push_back(res[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bra_pkg::out_item_t e;
		if (!arst_n) begin
			foreach (totals[i]) totals[i] = 0;
			for (int p = 0; p < PROCESSES; p++) begin
				waiting[p] = 0;
				for (int r = 0; r < RESOURCE_TYPES; r++) begin
					claim[p][r] = 0;
					held[p][r] = 0;
					pend[p][r] = 0;
				end
			end
			foreach (avail[r]) avail[r] = 0;
			expected_results.delete();
			errors = 0;
			result_cnt = 0;
			grant_cnt = 0;
			wait_cnt = 0;
		end else begin
			if (psel && penable && pwrite && pready)
				write_total(paddr >> 2, pwdata[7:0]);
			if (out_valid && !out_stall) begin
				result_cnt++;
				if (expected_results.size() == 0) begin
					e = '0;
					report("unexpected result", out_data, e);
				end else begin
					e = expected_results.pop_front();
					if (out_data.result_process !== e.result_process)
						report("result_process", out_data, e);
					if (out_data.status !== e.status) report("status", out_data, e);
					if (out_data.units_type0 !== e.units_type0) report("units_type0", out_data, e);
					if (out_data.units_type1 !== e.units_type1) report("units_type1", out_data, e);
					if (out_data.units_type2 !== e.units_type2) report("units_type2", out_data, e);
					if (out_data.units_type3 !== e.units_type3) report("units_type3", out_data, e);
					if (out_data.last_result !== e.last_result) report("last_result", out_data, e);
				end
			end
			if (in_valid && !in_stall) predict_request(in_data);
		end
	end
endmodule

FILE: tb/sv/tb_bankers_resource_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_bankers_resource_allocator_core: stimulus and verdict for the allocator
// drives claim/acquire/release requests and apb pool writes under random
// idling on both channels; the checker beside the block scores every result
// ----------------------------------------------------------------------------
module tb_bankers_resource_allocator_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PROCS = 8;
	localparam int NTYPES = 4;
	// worst release: every process re-checked, each a full-length safety check
	localparam int DRAIN_CYCLES = PROCS * (PROCS * PROCS + 4) + 50;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	bra_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	bra_pkg::out_item_t out_data;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [bra_pkg::ADDR_W-1:0] paddr = '0;
	logic [bra_pkg::DATA_W-1:0] pwdata = '0;
	logic [bra_pkg::DATA_W-1:0] prdata;
	logic pready;

	int errors, pending_cnt, result_cnt, grant_cnt, wait_cnt;
	int send_idle_pct = 0;   // chance in a hundred the sender skips a cycle
	int recv_idle_pct = 0;   // chance in a hundred the receiver stalls
	bit hold_off = 0;        // long receiver hold-off in progress
	int sent = 0;

	always #2 clk = ~clk;

	bankers_resource_allocator_core #(.PROCESSES(PROCS), .RESOURCE_TYPES(NTYPES)) DUT (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	bra_checker #(.PROCESSES(PROCS), .RESOURCE_TYPES(NTYPES)) u_checker (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.errors, .pending_cnt, .result_cnt, .grant_cnt, .wait_cnt
	);

	// receiver stall, changed only at the falling edge
	always @(negedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// hold-off counted in its own process, started inside a random phase so the
	// sender keeps offering requests and the block stalls its input
	initial begin
		@(posedge arst_n);
		wait (sent == 60);
		hold_off = 1;
		repeat (400) @(posedge clk);
		hold_off = 0;
	end

	// apb write: setup then access, pready always high
	task automatic pool_write(input int idx, input logic [7:0] val);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= bra_pkg::ADDR_W'(idx * 4); pwdata <= {24'd0, val};
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic set_pool(input logic [7:0] a, b, c, d);
		pool_write(0, a);
		pool_write(1, b);
		pool_write(2, c);
		pool_write(3, d);
	endtask

	// wait for quiet block before a configuration change
	task automatic drain();
		while (pending_cnt != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// offers one request, held until accepted
	task automatic send(input bra_pkg::req_kind_t k, input int pid,
			input logic [7:0] a, b, c, d);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= '{req_type: k, process_id: pid[bra_pkg::ID_W-1:0], amount_type0: a,
			amount_type1: b, amount_type2: c, amount_type3: d};
		@(posedge clk);
		while (!(in_valid && !in_stall)) @(posedge clk);
		sent++;
		@(negedge clk);
		in_valid <= 0;
	endtask

	// small amounts mostly so requests get past the claim checks
	function automatic logic [7:0] amt8(input int hi);
		return ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(hi));
	endfunction

	task automatic random_phase(input int n);
		int k, pid;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			pid = $urandom_range(PROCS - 1);
			if (k < 20)
				send(bra_pkg::REQ_CLAIM, pid, amt8(12), amt8(12), amt8(12), amt8(12));
			else if (k < 60)
				send(bra_pkg::REQ_ACQUIRE, pid, amt8(4), amt8(4), amt8(4), amt8(4));
			else if (k < 95)
				send(bra_pkg::REQ_RELEASE, pid, amt8(5), amt8(5), amt8(5), amt8(5));
			else
				send(bra_pkg::REQ_UNUSED, pid, amt8(255), amt8(255), amt8(255), amt8(255));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: zero pool, then extremes and every status except a short wait
		send(bra_pkg::REQ_CLAIM, 0, 1, 0, 0, 0);          // claim above total
		drain();
		set_pool(8'd255, 8'd255, 8'd255, 8'd255);
		send(bra_pkg::REQ_CLAIM, 7, 255, 255, 255, 255);
		send(bra_pkg::REQ_ACQUIRE, 7, 255, 255, 255, 255);
		send(bra_pkg::REQ_CLAIM, 7, 0, 0, 0, 0);          // below held
		send(bra_pkg::REQ_RELEASE, 7, 255, 255, 255, 255);
		send(bra_pkg::REQ_UNUSED, 3, 8'hAA, 8'h55, 8'hFF, 8'h00);
		drain();
		set_pool(8'd6, 8'd4, 8'd3, 8'd2);
		send(bra_pkg::REQ_CLAIM, 0, 6, 4, 3, 2);
		send(bra_pkg::REQ_CLAIM, 1, 6, 4, 3, 2);
		send(bra_pkg::REQ_ACQUIRE, 0, 7, 0, 0, 0);        // over claim
		send(bra_pkg::REQ_ACQUIRE, 0, 4, 2, 1, 1);        // granted
		send(bra_pkg::REQ_ACQUIRE, 1, 1, 1, 1, 0);        // unsafe wait
		send(bra_pkg::REQ_ACQUIRE, 1, 0, 0, 0, 0);        // busy while waiting
		send(bra_pkg::REQ_CLAIM, 2, 2, 0, 0, 0);
		send(bra_pkg::REQ_ACQUIRE, 2, 2, 0, 0, 0);        // granted
		send(bra_pkg::REQ_RELEASE, 0, 255, 255, 255, 255); // saturated release wakes the waiter
		send(bra_pkg::REQ_RELEASE, 1, 1, 1, 1, 1);
		send(bra_pkg::REQ_RELEASE, 2, 2, 0, 0, 0);
		send(bra_pkg::REQ_RELEASE, 5, 9, 9, 9, 9);        // holds nothing
		drain();

		set_pool(8'd10, 8'd8, 8'd12, 8'd7);
		send_idle_pct = 24; recv_idle_pct = 62;
		random_phase(34);
		drain();
		set_pool(8'd20, 8'd5, 8'd0, 8'd15);
		send_idle_pct = 62; recv_idle_pct = 24;
		random_phase(29);
		drain();
		set_pool(8'd16, 8'd16, 8'd16, 8'd16);
		send_idle_pct = 0; recv_idle_pct = 0;
		random_phase(28);

		while (pending_cnt != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests, %0d results (%0d grants, %0d waits)",
			sent, result_cnt, grant_cnt, wait_cnt);
		$display("pool settings from zero to 255 under three idling mixes");
		if (errors == 0 && pending_cnt == 0)
			$display("tb_bankers_resource_allocator_core passed");
		else
			$display("tb_bankers_resource_allocator_core failed");
		$finish;
	end

	initial begin
		#4ms;
		$display("tb_bankers_resource_allocator_core failed");
		$finish;
	end
endmodule
